FILE: hw/rtl/pbmt_pkg.sv
// Package: constants, codes and types shared by the pattern bank match table.
package pbmt_pkg;

  localparam int unsigned IdBits      = 10;
  localparam int unsigned ElementBits = 16;
  localparam int unsigned MaxLayers   = 8;
  localparam int unsigned MaxHits     = 64;

  // Input item kinds
  typedef enum logic [2:0] {
    KindClear  = 3'd0,
    KindInsert = 3'd1,
    KindLookup = 3'd2,
    KindMatch  = 3'd3,
    KindLayer  = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusNone  = 2'd1,
    StatusTrunc = 2'd2,
    StatusDup   = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StClear,
    StRead,
    StWrite,
    StScan,
    StFlush
  } state_e;

  // Configuration register indexes
  localparam logic [0:0] RegLayersInUse = 1'd0;

endpackage

FILE: hw/rtl/pbmt_lane.sv
// One compare lane: checks one stored element against its key element.
module pbmt_lane import pbmt_pkg::*; #(
  parameter int unsigned ELEMENT_BITS = ElementBits
) (
  input  logic [ELEMENT_BITS-1:0] stored_i,
  input  logic [ELEMENT_BITS-1:0] key_i,
  input  logic                    enable_i,
  output logic                    equal_o
);

  // Lane disabled counts as a pass
  assign equal_o = !enable_i || (stored_i == key_i);

endmodule

FILE: hw/rtl/pbmt_merge.sv
// Merging stage: combines lane results into one hit for match or layer query.
module pbmt_merge import pbmt_pkg::*; #(
  parameter int unsigned MAX_LAYERS = MaxLayers
) (
  input  logic [MAX_LAYERS-1:0] lane_eq_i,
  input  logic                  layer_mode_i,
  input  logic                  layer_ok_i,
  output logic                  hit_o
);

  // Full match needs all lanes; layer query has only the chosen lane enabled
  assign hit_o = layer_mode_i ? (layer_ok_i && (&lane_eq_i)) : (&lane_eq_i);

endmodule

FILE: hw/rtl/pattern_bank_match_table_core.sv
// Top level: pattern bank with id-addressed store and lane-parallel scan.
// After reset the block runs a clearing pass over the valid store, with busy
// high throughout. After an accepted word, busy stays high through these
// steps: on a clear, one valid bit cleared per cycle, then the result; on an
// insert, valid read, write, result; on a lookup, registered memory read,
// then the result; on a match or layer query, the scan reads one stored id
// per cycle from the memory's one read port, all layers compare in parallel
// lanes on the registered read data, and the last word follows the scan.
// The next word can be taken at the edge after busy falls. Results appear
// for one cycle on result_valid_o and cannot be stalled by the receiver;
// busy is high from acceptance until the last result has been shown.
module pattern_bank_match_table_core import pbmt_pkg::*; #(
  parameter int unsigned ID_BITS      = IdBits,
  parameter int unsigned ELEMENT_BITS = ElementBits,
  parameter int unsigned MAX_LAYERS   = MaxLayers,
  parameter int unsigned MAX_HITS     = MaxHits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              kind_i,
  input  logic [ID_BITS-1:0]      pattern_id_i,
  input  logic [2:0]              layer_select_i,
  input  logic [ELEMENT_BITS-1:0] element_0_i,
  input  logic [ELEMENT_BITS-1:0] element_1_i,
  input  logic [ELEMENT_BITS-1:0] element_2_i,
  input  logic [ELEMENT_BITS-1:0] element_3_i,
  input  logic [ELEMENT_BITS-1:0] element_4_i,
  input  logic [ELEMENT_BITS-1:0] element_5_i,
  input  logic [ELEMENT_BITS-1:0] element_6_i,
  input  logic [ELEMENT_BITS-1:0] element_7_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic [ID_BITS-1:0]      hit_id_o,
  output logic [ELEMENT_BITS-1:0] found_element_0_o,
  output logic [ELEMENT_BITS-1:0] found_element_1_o,
  output logic [ELEMENT_BITS-1:0] found_element_2_o,
  output logic [ELEMENT_BITS-1:0] found_element_3_o,
  output logic [ELEMENT_BITS-1:0] found_element_4_o,
  output logic [ELEMENT_BITS-1:0] found_element_5_o,
  output logic [ELEMENT_BITS-1:0] found_element_6_o,
  output logic [ELEMENT_BITS-1:0] found_element_7_o,
  output logic                    last_result_o,
  output logic [ID_BITS:0]        stored_count_o
);

  localparam int unsigned NumIds  = 1 << ID_BITS;
  localparam int unsigned RowBits = MAX_LAYERS * ELEMENT_BITS;
  localparam int unsigned HitBits = $clog2(MAX_HITS + 1);
  localparam int unsigned LayBits = $clog2(MAX_LAYERS + 1);

  // Configuration register
  logic [3:0] layers_q;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {28'd0, layers_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layers_q <= 4'd8;
    end else if (cfg_wr && (paddr[1:0] == {RegLayersInUse, 1'b0})) begin
      layers_q <= pwdata[3:0];
    end
  end

  // Effective layer count
  logic [LayBits-1:0] nl;
  always_comb begin
    if (layers_q == 4'd0) begin
      nl = LayBits'(1);
    end else if (32'(layers_q) > MAX_LAYERS) begin
      nl = LayBits'(MAX_LAYERS);
    end else begin
      nl = LayBits'(layers_q);
    end
  end

  // Input elements gathered into lanes
  logic [ELEMENT_BITS-1:0] elem_in [8];
  assign elem_in[0] = element_0_i;
  assign elem_in[1] = element_1_i;
  assign elem_in[2] = element_2_i;
  assign elem_in[3] = element_3_i;
  assign elem_in[4] = element_4_i;
  assign elem_in[5] = element_5_i;
  assign elem_in[6] = element_6_i;
  assign elem_in[7] = element_7_i;

  // Pattern memory and valid store
  logic [RowBits-1:0] mem [NumIds];
  logic               valid_mem [NumIds];
  logic [RowBits-1:0] rd_q;
  logic               rd_valid_q;

  // Item registers
  state_e              state_q, state_d;
  kind_e               kind_q;
  logic [ID_BITS-1:0]  id_q;
  logic [2:0]          sel_q;
  logic [ELEMENT_BITS-1:0] key_q [MAX_LAYERS];
  logic [ID_BITS:0]    total_q;
  logic [ID_BITS:0]    ptr_q;      // read or clear address counter
  logic [ID_BITS-1:0]  cmp_id_q;   // id of row in rd_q
  logic                cmp_v_q;    // rd_q holds a scanned row
  logic [HitBits-1:0]  hits_q;
  logic                pend_q;     // one hit held back
  logic [ID_BITS-1:0]  pend_id_q;
  logic                trunc_q;

  logic                accept;
  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // Lanes and merge
  logic [MAX_LAYERS-1:0] lane_eq;
  logic                  hit;
  for (genvar l = 0; l < MAX_LAYERS; l++) begin : g_lane
    logic en;
    assign en = (kind_q == KindLayer) ? (32'(sel_q) == l)
                                      : (32'(l) < 32'(nl));
    pbmt_lane #(.ELEMENT_BITS(ELEMENT_BITS)) u_lane (
      .stored_i (rd_q[l*ELEMENT_BITS +: ELEMENT_BITS]),
      .key_i    ((kind_q == KindLayer) ? key_q[0] : key_q[l]),
      .enable_i (en),
      .equal_o  (lane_eq[l])
    );
  end
  pbmt_merge #(.MAX_LAYERS(MAX_LAYERS)) u_merge (
    .lane_eq_i    (lane_eq),
    .layer_mode_i (kind_q == KindLayer),
    .layer_ok_i   ((32'(sel_q) < 32'(nl)) && (32'(sel_q) < MAX_LAYERS)),
    .hit_o        (hit)
  );

  logic scan_hit;
  assign scan_hit = cmp_v_q && rd_valid_q && hit && !trunc_q;

  // Row written by an insert, taken from the held word
  logic [RowBits-1:0] wr_row;
  always_comb begin
    for (int l = 0; l < MAX_LAYERS; l++) begin
      wr_row[l*ELEMENT_BITS +: ELEMENT_BITS] = key_q[l];
    end
  end

  logic [ID_BITS-1:0] rd_addr;
  assign rd_addr = (state_q == StScan) ? ptr_q[ID_BITS-1:0] : id_q;

  // Insert writes only when the id was free; clearing walks the valid store
  logic ins_wr;
  logic clr_wr;
  assign ins_wr = (state_q == StWrite) && !rd_valid_q;
  assign clr_wr = (state_q == StClear) || (state_q == StInit);

  // Pattern memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ins_wr) begin
      mem[id_q] <= wr_row;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (clr_wr) begin
      valid_mem[ptr_q[ID_BITS-1:0]] <= 1'b0;
    end else if (ins_wr) begin
      valid_mem[id_q] <= 1'b1;
    end
    rd_valid_q <= valid_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StInit:  if (ptr_q == (ID_BITS+1)'(NumIds - 1)) state_d = StIdle;
      StIdle: begin
        if (accept) begin
          case (kind_i)
            KindClear:            state_d = StClear;
            KindInsert:           state_d = StRead;
            KindLookup:           state_d = StRead;
            KindMatch, KindLayer: state_d = StScan;
            default:              state_d = StIdle;
          endcase
        end
      end
      StClear: if (ptr_q == (ID_BITS+1)'(NumIds - 1)) state_d = StFlush;
      StRead:  state_d = (kind_q == KindInsert) ? StWrite : StFlush;
      StWrite: state_d = StFlush;
      StScan:  if (!cmp_v_q && ptr_q[ID_BITS]) state_d = StFlush;
      StFlush: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StInit;
      total_q  <= '0;
      ptr_q    <= '0;
      cmp_v_q  <= 1'b0;
      hits_q   <= '0;
      pend_q   <= 1'b0;
      trunc_q  <= 1'b0;
      kind_q   <= KindClear;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          ptr_q   <= '0;
          cmp_v_q <= 1'b0;
          hits_q  <= '0;
          pend_q  <= 1'b0;
          trunc_q <= 1'b0;
          if (accept) begin
            kind_q <= kind_e'(kind_i);
          end
        end
        StInit, StClear: begin
          ptr_q   <= ptr_q + 1'b1;
          total_q <= '0;
        end
        StWrite: begin
          if (!rd_valid_q) total_q <= total_q + 1'b1;
        end
        StScan: begin
          if (!ptr_q[ID_BITS]) ptr_q <= ptr_q + 1'b1;
          cmp_v_q <= !ptr_q[ID_BITS];
          if (scan_hit) begin
            if (hits_q == HitBits'(MAX_HITS)) begin
              trunc_q <= 1'b1;
            end else begin
              hits_q <= hits_q + 1'b1;
              pend_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Item payload and scan ids
  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q  <= pattern_id_i;
      sel_q <= layer_select_i;
      for (int l = 0; l < MAX_LAYERS; l++) key_q[l] <= elem_in[l];
    end
    cmp_id_q <= rd_addr;
    if (scan_hit && (hits_q != HitBits'(MAX_HITS))) pend_id_q <= cmp_id_q;
  end

  // Result word
  logic [ELEMENT_BITS-1:0] found [8];
  always_comb begin
    result_valid_o = 1'b0;
    status_o       = StatusOk;
    hit_id_o       = id_q;
    last_result_o  = 1'b0;
    for (int l = 0; l < 8; l++) found[l] = '0;
    case (state_q)
      StScan: begin
        // hold one hit back, emit it when the next one is found
        if (pend_q && scan_hit && (hits_q != HitBits'(MAX_HITS))) begin
          result_valid_o = 1'b1;
          hit_id_o       = pend_id_q;
        end
      end
      StFlush: begin
        result_valid_o = 1'b1;
        last_result_o  = 1'b1;
        case (kind_q)
          // rd_valid_q still holds the valid bit read before the write
          KindInsert: status_o = rd_valid_q ? StatusDup : StatusOk;
          KindLookup: begin
            status_o = rd_valid_q ? StatusOk : StatusNone;
            if (rd_valid_q) begin
              for (int l = 0; l < MAX_LAYERS; l++) begin
                if (32'(l) < 32'(nl)) found[l] = rd_q[l*ELEMENT_BITS +: ELEMENT_BITS];
              end
            end
          end
          KindMatch, KindLayer: begin
            if (!pend_q) begin
              status_o = StatusNone;
              hit_id_o = '0;
            end else begin
              status_o = trunc_q ? StatusTrunc : StatusOk;
              hit_id_o = pend_id_q;
            end
          end
          default: status_o = StatusOk;
        endcase
      end
      default: ;
    endcase
  end

  assign found_element_0_o = found[0];
  assign found_element_1_o = found[1];
  assign found_element_2_o = found[2];
  assign found_element_3_o = found[3];
  assign found_element_4_o = found[4];
  assign found_element_5_o = found[5];
  assign found_element_6_o = found[6];
  assign found_element_7_o = found[7];
  assign stored_count_o    = total_q;

endmodule

FILE: verif/tb_pattern_bank_match_table_core.sv
// Testbench for the pattern bank match table: predicted results checked word by word.
`timescale 1ns / 100ps

module tb_pattern_bank_match_table_core;
  import pbmt_pkg::*;

  typedef struct packed {
    logic [2:0]       kind;
    logic [9:0]       pid;
    logic [2:0]       lsel;
    logic [7:0][15:0] elem;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [9:0]       hit_id;
    logic [7:0][15:0] found;
    logic             last;
    logic [10:0]      count;
  } word_t;

  // Marks a pause for a layers_in_use write in the pending queue
  typedef struct {
    bit         is_cfg;
    logic [3:0] cfg_val;
    cmd_t       cmd;
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  cmd_t drv = '0;
  logic result_valid_o, last_result_o;
  logic [1:0] status_o;
  logic [9:0] hit_id_o;
  logic [15:0] fe0, fe1, fe2, fe3, fe4, fe5, fe6, fe7;
  logic [10:0] stored_count_o;

  always #10 clk_i = ~clk_i;

  pattern_bank_match_table_core u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .kind_i(drv.kind), .pattern_id_i(drv.pid), .layer_select_i(drv.lsel),
    .element_0_i(drv.elem[0]), .element_1_i(drv.elem[1]), .element_2_i(drv.elem[2]),
    .element_3_i(drv.elem[3]), .element_4_i(drv.elem[4]), .element_5_i(drv.elem[5]),
    .element_6_i(drv.elem[6]), .element_7_i(drv.elem[7]),
    .result_valid_o, .status_o, .hit_id_o,
    .found_element_0_o(fe0), .found_element_1_o(fe1), .found_element_2_o(fe2),
    .found_element_3_o(fe3), .found_element_4_o(fe4), .found_element_5_o(fe5),
    .found_element_6_o(fe6), .found_element_7_o(fe7),
    .last_result_o, .stored_count_o
  );

  // Predictor state
  bit               bank_valid [1024];
  logic [7:0][15:0] bank_store [1024];
  logic [10:0]      bank_total;
  logic [3:0]       layers_reg;
  word_t            expected_words [$];
  pending_t         pending [$];
  int               idle_pct = 0;
  bit               fail = 0;
  bit               all_sent = 0;
  int               quiet_cycles = 0;

  function automatic int active_layers();
    if (layers_reg == 0) return 1;
    if (layers_reg > 8) return 8;
    return int'(layers_reg);
  endfunction

  function automatic word_t mk_word(logic [1:0] st, logic [9:0] id);
    word_t w;
    w = '0;
    w.status = st;
    w.hit_id = id;
    w.count = bank_total;
    return w;
  endfunction

  // Work out the words one command causes and queue them
  task automatic predict_words(cmd_t c);
    int nl, hits;
    bit hit, trunc;
    word_t w;
    nl = active_layers();
    hits = 0;
    trunc = 0;
    case (c.kind)
      KindClear: begin
        foreach (bank_valid[i]) bank_valid[i] = 0;
        bank_total = 0;
        w = mk_word(StatusOk, c.pid);
        w.last = 1;
        expected_words = {expected_words, w};
      end
      KindInsert: begin
        if (bank_valid[c.pid]) begin
          w = mk_word(StatusDup, c.pid);
        end else begin
          bank_valid[c.pid] = 1;
          bank_store[c.pid] = c.elem;
          bank_total++;
          w = mk_word(StatusOk, c.pid);
        end
        w.last = 1;
        expected_words = {expected_words, w};
      end
      KindLookup: begin
        if (bank_valid[c.pid]) begin
          w = mk_word(StatusOk, c.pid);
          for (int l = 0; l < nl; l++) w.found[l] = bank_store[c.pid][l];
        end else begin
          w = mk_word(StatusNone, c.pid);
        end
        w.last = 1;
        expected_words = {expected_words, w};
      end
      KindMatch, KindLayer: begin
        for (int i = 0; i < 1024; i++) begin
          if (!bank_valid[i]) continue;
          if (c.kind == KindMatch) begin
            hit = 1;
            for (int l = 0; l < nl; l++) if (bank_store[i][l] != c.elem[l]) hit = 0;
          end else begin
            hit = (c.lsel < nl) && (bank_store[i][c.lsel] == c.elem[0]);
          end
          if (!hit) continue;
          if (hits >= MaxHits) begin
            trunc = 1;
            break;
          end
          expected_words = {expected_words, mk_word(StatusOk, i[9:0])};
          hits++;
        end
        if (hits == 0) begin
          w = mk_word(StatusNone, '0);
          expected_words = {expected_words, w};
        end else if (trunc) begin
          expected_words[$].status = StatusTrunc;
        end
        expected_words[$].last = 1;
      end
      default: ;
    endcase
  endtask

  // Driver: feeds commands, holds back configuration until the bank is idle
  int cfg_phase = 0;
  int settle = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_words(drv);
        quiet_cycles = 0;
      end
      if (cfg_phase == 1) begin
        psel <= 1'b1;
        penable <= 1'b1;
        cfg_phase = 2;
      end else if (cfg_phase == 2) begin
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        layers_reg = pending[0].cfg_val;
        void'(pending.pop_front());
        cfg_phase = 0;
      end else if (start && !busy || !start) begin
        if (pending.size() == 0) begin
          start <= 1'b0;
          if (!start || !busy) all_sent = 1;
        end else if (pending[0].is_cfg) begin
          start <= 1'b0;
          if (!(start && !busy) && !busy && expected_words.size() == 0) begin
            if (settle < 8) begin
              settle++;
            end else begin
              settle = 0;
              psel <= 1'b1;
              pwrite <= 1'b1;
              paddr <= {RegLayersInUse, 1'b0};
              pwdata <= {28'd0, pending[0].cfg_val};
              cfg_phase = 1;
            end
          end
        end else if ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
        end else begin
          drv <= pending[0].cmd;
          start <= 1'b1;
          void'(pending.pop_front());
        end
      end
    end
  end

  // Monitor: compares each shown word with the oldest prediction
  always @(posedge clk_i) begin
    word_t e;
    if (rst_ni) begin
      quiet_cycles++;
      if (result_valid_o) begin
        quiet_cycles = 0;
        if (expected_words.size() == 0) begin
          $error("unexpected word: hit_id %0d status %0d", hit_id_o, status_o);
          fail = 1;
        end else begin
          e = expected_words.pop_front();
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); fail = 1;
          end
          if (hit_id_o !== e.hit_id) begin
            $error("hit_id exp %0d got %0d", e.hit_id, hit_id_o); fail = 1;
          end
          if ({fe7, fe6, fe5, fe4, fe3, fe2, fe1, fe0} !== e.found) begin
            $error("found_element exp %h got %h", e.found,
                   {fe7, fe6, fe5, fe4, fe3, fe2, fe1, fe0});
            fail = 1;
          end
          if (last_result_o !== e.last) begin
            $error("last_result exp %0d got %0d", e.last, last_result_o); fail = 1;
          end
          if (stored_count_o !== e.count) begin
            $error("stored_count exp %0d got %0d", e.count, stored_count_o); fail = 1;
          end
        end
      end
      if (quiet_cycles > 20000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic cmd_t rand_cmd(logic [2:0] k, logic [9:0] id);
    cmd_t c;
    c.kind = k;
    c.pid = id;
    c.lsel = 3'($urandom_range(7));
    for (int l = 0; l < 8; l++) c.elem[l] = 16'($urandom);
    return c;
  endfunction

  task automatic push_cmd(cmd_t c);
    pending_t p;
    p.is_cfg = 0;
    p.cfg_val = '0;
    p.cmd = c;
    pending = {pending, p};
  endtask

  task automatic push_cfg(logic [3:0] v);
    pending_t p;
    p.is_cfg = 1;
    p.cfg_val = v;
    p.cmd = '0;
    pending = {pending, p};
  endtask

  // Stimulus: directed corners, then random phases with differing idle rates
  initial begin
    cmd_t c, shadow [$];
    int pick;
    logic [9:0] id;
    layers_reg = 4'd8;
    bank_total = 0;
    foreach (bank_valid[i]) bank_valid[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, duplicates, truncation, every kind
    c = rand_cmd(KindInsert, 10'd0); c.elem = '0; push_cmd(c);
    c = rand_cmd(KindInsert, 10'd1023); c.elem = '1; push_cmd(c);
    push_cmd(c);
    c = rand_cmd(KindLookup, 10'd1023); push_cmd(c);
    c = rand_cmd(KindLookup, 10'd5); push_cmd(c);
    c = rand_cmd(KindMatch, 10'd0); c.elem = '1; push_cmd(c);
    c = rand_cmd(KindMatch, 10'd0); push_cmd(c);
    c = rand_cmd(KindLayer, 10'd0); c.lsel = 3'd7; c.elem[0] = 16'hffff; push_cmd(c);
    for (int i = 0; i < 66; i++) begin
      c = rand_cmd(KindInsert, 10'(100 + i)); c.elem[3] = 16'h5a5a; push_cmd(c);
    end
    c = rand_cmd(KindLayer, 10'd0); c.lsel = 3'd3; c.elem[0] = 16'h5a5a; push_cmd(c);
    for (int k5 = 5; k5 < 8; k5++) push_cmd(rand_cmd(k5[2:0], 10'd3));
    push_cfg(4'd0);
    c = rand_cmd(KindLayer, 10'd0); c.lsel = 3'd3; c.elem[0] = 16'h5a5a; push_cmd(c);
    c = rand_cmd(KindMatch, 10'd0); c.elem[0] = 16'hffff; push_cmd(c);
    c = rand_cmd(KindLookup, 10'd1023); push_cmd(c);
    push_cfg(4'd15);
    c = rand_cmd(KindLookup, 10'd1023); push_cmd(c);
    c = rand_cmd(KindClear, 10'd777); push_cmd(c);
    c = rand_cmd(KindLookup, 10'd0); push_cmd(c);

    // Random phases; inserts reuse earlier element sets so matches hit
    for (int ph = 0; ph < 4; ph++) begin
      while (pending.size() > 0 || !all_sent || expected_words.size() > 0)
        @(posedge clk_i);
      all_sent = 0;
      idle_pct = (ph == 1) ? 52 : (ph == 3) ? 22 : 0;
      push_cfg(ph == 3 ? 4'd1 : 4'($urandom_range(1, 8)));
      shadow.delete();
      for (int n = 0; n < 92; n++) begin
        pick = $urandom_range(99);
        id = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(31));
        if (pick < 45) begin
          c = rand_cmd(KindInsert, id);
          if (shadow.size() > 0 && $urandom_range(1)) begin
            c.elem = shadow[$urandom_range(shadow.size() - 1)].elem;
            c.elem[$urandom_range(7)] = 16'($urandom);
          end
          if ($urandom_range(9) == 0) c.elem = '1;
          shadow = {shadow, c};
        end else if (pick < 60) begin
          c = rand_cmd(KindLookup, id);
        end else if (pick < 78) begin
          c = rand_cmd(KindMatch, id);
          if (shadow.size() > 0 && $urandom_range(3) != 0)
            c.elem = shadow[$urandom_range(shadow.size() - 1)].elem;
        end else if (pick < 95) begin
          c = rand_cmd(KindLayer, id);
          if (shadow.size() > 0 && $urandom_range(3) != 0)
            c.elem[0] = shadow[$urandom_range(shadow.size() - 1)].elem[c.lsel];
        end else if (pick < 98) begin
          c = rand_cmd(KindClear, id);
        end else begin
          c = rand_cmd(3'($urandom_range(5, 7)), id);
        end
        push_cmd(c);
      end
    end

    while (pending.size() > 0 || !all_sent || expected_words.size() > 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (!fail && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pbmt_pkg.sv
hw/rtl/pbmt_lane.sv
hw/rtl/pbmt_merge.sv
hw/rtl/pattern_bank_match_table_core.sv
verif/tb_pattern_bank_match_table_core.sv
